FILE: rtl/core/lbc_pkg.sv
// Shared types and constants of the light bearing centroid block.
`default_nettype none

package lbc_pkg;

    localparam int MaxSensorsDef = 6;   // default sensors per frame
    localparam int NumAngles     = 6;   // mount angle registers
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 15;
    localparam int AngleW        = 15;
    localparam int LevelW        = 12;
    localparam int CountW        = 3;
    localparam int SumLaW        = 32;  // sum of reading * angle
    localparam int SumAW         = 18;  // sum of angles
    localparam int SumLW         = 15;  // sum of readings
    localparam int NumW          = SumLaW + 1;
    localparam int QuotW         = 16;  // quotient bits developed by the divider
    localparam int StepBits      = 4;   // quotient bits per divider cycle
    localparam int DivCycles     = QuotW / StepBits;

    localparam logic [LevelW-1:0] ThresholdRst = LevelW'(2048);

    // register indexes; 0 .. NumAngles-1 are the mount angles
    localparam logic [CfgIdxW-1:0] RegSensorCount   = CfgIdxW'(6);
    localparam logic [CfgIdxW-1:0] RegLevelThreshold = CfgIdxW'(7);

    typedef logic [NumAngles-1:0][AngleW-1:0] angle_set_t;

    typedef struct packed {
        logic acc;      // accumulate the item on the input ports
        logic fin;      // form numerator/denominator, clear frame
        logic step;     // one divider step
        logic finish;   // last divider step, load result
    } lbc_cmd_t;

    typedef struct packed {
        logic count_nz; // sensor count is nonzero
        logic last;     // current slot ends the frame
    } lbc_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lbc_regs.sv
// Configuration register file: mount angles, sensor count, threshold.
`default_nettype none

module lbc_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lbc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [lbc_pkg::CfgDataW-1:0]  cfg_data,
    output      lbc_pkg::angle_set_t           angles,
    output      logic [lbc_pkg::CountW-1:0]    sensor_count,
    output      logic [lbc_pkg::LevelW-1:0]    level_threshold
);

    lbc_pkg::angle_set_t                angle_reg;
    logic [lbc_pkg::CountW-1:0]         count_reg;
    logic [lbc_pkg::LevelW-1:0]         thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= '0;
            count_reg  <= '0;
            thresh_reg <= lbc_pkg::ThresholdRst;
        end
        else if (cfg_we)
        begin
            priority if (cfg_index == lbc_pkg::RegSensorCount)
            begin
                count_reg <= cfg_data[lbc_pkg::CountW-1:0];
            end
            else if (cfg_index == lbc_pkg::RegLevelThreshold)
            begin
                thresh_reg <= cfg_data[lbc_pkg::LevelW-1:0];
            end
            else
            begin
                angle_reg[cfg_index] <= cfg_data[lbc_pkg::AngleW-1:0];
            end
        end
    end

    assign angles          = angle_reg;
    assign sensor_count    = count_reg;
    assign level_threshold = thresh_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lbc_ctrl.sv
// Frame controller: accepts items, sequences end-of-frame math and division.
`default_nettype none

module lbc_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lbc_pkg::lbc_status_t status,
    output      lbc_pkg::lbc_cmd_t  cmd,
    output      logic               busy,
    output      logic               done
);

    localparam int CntW = (lbc_pkg::DivCycles > 1) ? $clog2(lbc_pkg::DivCycles) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(lbc_pkg::DivCycles - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_DIV
    } state_t;

    state_t            state_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              done_reg;
    logic              accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    always_comb
    begin
        cmd.acc    = accept && status.count_nz;
        cmd.fin    = (state_reg == ST_FIN);
        cmd.step   = (state_reg == ST_DIV);
        cmd.finish = (state_reg == ST_DIV) && (cnt_reg == CntLast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.acc && status.last)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == CntLast)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CntW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lbc_dp.sv
// Datapath: running sums per item, ambient correction, radix-16 divider.
`default_nettype none

module lbc_dp
#(
    parameter int MAX_SENSORS = lbc_pkg::MaxSensorsDef
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lbc_pkg::lbc_cmd_t                  cmd,
    output      lbc_pkg::lbc_status_t               status,
    input  wire lbc_pkg::angle_set_t                angles,
    input  wire logic [lbc_pkg::CountW-1:0]         sensor_count,
    input  wire logic [lbc_pkg::LevelW-1:0]         level_threshold,
    input  wire logic [lbc_pkg::LevelW-1:0]         reading,
    input  wire logic                               present,
    output      logic signed [lbc_pkg::AngleW-1:0]  bearing,
    output      logic [lbc_pkg::LevelW-1:0]         peak_level,
    output      logic                               level_hit
);

    localparam int SlotW = $clog2(MAX_SENSORS);
    localparam int PtW   = $clog2(MAX_SENSORS + 1);
    localparam int NW    = lbc_pkg::CountW + 1;     // holds count and MAX_SENSORS
    localparam int IdxW  = $clog2(lbc_pkg::NumAngles);
    localparam int LW    = lbc_pkg::LevelW;
    localparam int AW    = lbc_pkg::AngleW;
    localparam int QW    = lbc_pkg::QuotW;
    localparam int SB    = lbc_pkg::StepBits;
    localparam int DenW  = lbc_pkg::SumLW;
    localparam logic [NW-1:0] MaxN = NW'(MAX_SENSORS);

    // frame state
    logic [SlotW-1:0]                   slot_reg;
    logic [PtW-1:0]                     pt_reg;
    logic [LW-1:0]                      amb_reg;
    logic [LW-1:0]                      peak_reg;
    logic                               above_reg;
    logic signed [lbc_pkg::SumLaW-1:0]  sla_reg;
    logic signed [lbc_pkg::SumAW-1:0]   sa_reg;
    logic [lbc_pkg::SumLW-1:0]          sl_reg;

    // divider state
    logic                               neg_reg;
    logic                               zero_reg;
    logic [DenW-1:0]                    den_reg;
    logic [QW-1:0]                      rem_reg;
    logic [QW-1:0]                      dvd_reg;
    logic [QW-1:0]                      quo_reg;

    // results
    logic signed [AW-1:0]               bearing_reg;
    logic [LW-1:0]                      peak_out_reg;
    logic                               above_out_reg;

    logic [NW-1:0]                      n_eff;
    logic [NW-1:0]                      slot_inc;
    logic [IdxW:0]                      slot_ext;
    logic signed [AW-1:0]               ang;
    logic signed [LW+AW:0]              prod_la;
    logic signed [LW+lbc_pkg::SumAW:0]  prod_as;
    logic [LW+PtW-1:0]                  prod_ap;
    logic signed [lbc_pkg::NumW-1:0]    num;
    logic [lbc_pkg::NumW-1:0]           mag;
    logic [LW+PtW-1:0]                  den_full;
    logic [DenW-1:0]                    den;
    logic                               n_small;
    logic [QW-1:0]                      rem_nx;
    logic [QW-1:0]                      dvd_nx;
    logic [QW-1:0]                      quo_nx;
    logic [QW:0]                        trial;
    logic [AW-1:0]                      qmag;

    // count saturates to MAX_SENSORS
    always_comb
    begin
        n_eff    = ({1'b0, sensor_count} > MaxN) ? MaxN : {1'b0, sensor_count};
        slot_inc = NW'(slot_reg) + NW'(1);
        slot_ext = (IdxW + 1)'(slot_reg);
        status.count_nz = (sensor_count != '0);
        status.last     = (slot_inc >= n_eff);
    end

    // slots past the angle registers carry angle zero
    always_comb
    begin
        if (slot_ext < (IdxW + 1)'(lbc_pkg::NumAngles))
        begin
            ang = $signed(angles[slot_ext[IdxW-1:0]]);
        end
        else
        begin
            ang = '0;
        end
        prod_la = $signed({1'b0, reading}) * ang;
    end

    // end of frame: remove ambient from the sums
    always_comb
    begin
        prod_as  = $signed({1'b0, amb_reg}) * sa_reg;
        prod_ap  = amb_reg * pt_reg;
        num      = lbc_pkg::NumW'(sla_reg) - lbc_pkg::NumW'(prod_as);
        mag      = num[lbc_pkg::NumW-1] ? lbc_pkg::NumW'(-num) : lbc_pkg::NumW'(num);
        den_full = (LW + PtW)'(sl_reg) - prod_ap;
        den      = den_full[DenW-1:0];
        n_small  = (n_eff < NW'(2));
    end

    // restoring division, SB quotient bits per cycle
    always_comb
    begin
        rem_nx = rem_reg;
        dvd_nx = dvd_reg;
        quo_nx = quo_reg;
        for (int i = 0; i < SB; i++)
        begin
            trial  = {rem_nx, dvd_nx[QW-1]};
            dvd_nx = {dvd_nx[QW-2:0], 1'b0};
            if (trial >= (QW + 1)'(den_reg))
            begin
                rem_nx = QW'(trial - (QW + 1)'(den_reg));
                quo_nx = {quo_nx[QW-2:0], 1'b1};
            end
            else
            begin
                rem_nx = trial[QW-1:0];
                quo_nx = {quo_nx[QW-2:0], 1'b0};
            end
        end
        qmag = quo_nx[AW-1:0];
    end

    // control-bearing frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            pt_reg    <= '0;
            amb_reg   <= '0;
            peak_reg  <= '0;
            above_reg <= 1'b0;
            sla_reg   <= '0;
            sa_reg    <= '0;
            sl_reg    <= '0;
        end
        else if (cmd.fin)
        begin
            slot_reg  <= '0;
            pt_reg    <= '0;
            amb_reg   <= '0;
            peak_reg  <= '0;
            above_reg <= 1'b0;
            sla_reg   <= '0;
            sa_reg    <= '0;
            sl_reg    <= '0;
        end
        else if (cmd.acc)
        begin
            slot_reg <= status.last ? '0 : slot_inc[SlotW-1:0];
            if (slot_reg == '0)
            begin
                amb_reg <= present ? reading : '0;
            end
            else if (present && (reading < amb_reg))
            begin
                amb_reg <= reading;
            end
            if (present)
            begin
                if (reading > peak_reg)
                begin
                    peak_reg <= reading;
                end
                if (reading >= level_threshold)
                begin
                    above_reg <= 1'b1;
                end
                pt_reg  <= pt_reg + PtW'(1);
                sl_reg  <= sl_reg + lbc_pkg::SumLW'(reading);
                sa_reg  <= sa_reg + lbc_pkg::SumAW'(ang);
                sla_reg <= sla_reg + lbc_pkg::SumLaW'(prod_la);
            end
        end
    end

    // divider and result registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            neg_reg       <= num[lbc_pkg::NumW-1];
            zero_reg      <= n_small || (den == '0);
            den_reg       <= den;
            rem_reg       <= mag[2*QW-1:QW];
            dvd_reg       <= mag[QW-1:0];
            quo_reg       <= '0;
            peak_out_reg  <= peak_reg;
            above_out_reg <= above_reg;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_nx;
            dvd_reg <= dvd_nx;
            quo_reg <= quo_nx;
        end
        if (cmd.finish)
        begin
            if (zero_reg)
            begin
                bearing_reg <= '0;
            end
            else
            begin
                bearing_reg <= neg_reg ? $signed(-qmag) : $signed(qmag);
            end
        end
    end

    assign bearing    = bearing_reg;
    assign peak_level = peak_out_reg;
    assign level_hit  = above_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/light_bearing_centroid_unit.sv
// Top level of the light bearing centroid block.
//
// Usage:
//   Items are sensor readings (reading, present) given in sensor order;
//   an item is taken at a rising edge with start high and busy low.
//   After sensor_count items (MAX_SENSORS at most) one result (bearing,
//   peak_level, level_hit) shows for a single cycle with done high and
//   cannot be held off. Items taken with sensor_count zero are dropped.
// Timing:
//   Items inside a frame go in one per cycle (one 12x15 multiply-add).
//   The frame's last item raises busy: the FIN state removes ambient
//   from the sums, then the DIV state runs the radix-16 divider.
//   done rises as busy falls; the next item can be taken at the edge
//   that ends done.
// Reset: rst_n clears frame state and the configuration registers;
//   level_threshold comes up at 2048, angles and sensor_count at zero.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge,
//   no wait; writes belong between frames.
`default_nettype none

module light_bearing_centroid_unit
#(
    parameter int MAX_SENSORS = lbc_pkg::MaxSensorsDef
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item channel
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [lbc_pkg::LevelW-1:0]        reading,
    input  wire logic                              present,
    // result channel
    output      logic                              done,
    output      logic signed [lbc_pkg::AngleW-1:0] bearing,
    output      logic [lbc_pkg::LevelW-1:0]        peak_level,
    output      logic                              level_hit,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [lbc_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [lbc_pkg::CfgDataW-1:0]      cfg_data
);

    lbc_pkg::angle_set_t             angles;
    logic [lbc_pkg::CountW-1:0]      sensor_count;
    logic [lbc_pkg::LevelW-1:0]      level_threshold;
    lbc_pkg::lbc_cmd_t               cmd;
    lbc_pkg::lbc_status_t            status;

    lbc_regs u_regs
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .angles          (angles),
        .sensor_count    (sensor_count),
        .level_threshold (level_threshold)
    );

    // controller: item accept, end-of-frame sequence, done strobe
    lbc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: running sums, ambient removal, divider, result registers
    lbc_dp
    #(
        .MAX_SENSORS (MAX_SENSORS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .angles          (angles),
        .sensor_count    (sensor_count),
        .level_threshold (level_threshold),
        .reading         (reading),
        .present         (present),
        .bearing         (bearing),
        .peak_level      (peak_level),
        .level_hit       (level_hit)
    );

endmodule

`default_nettype wire
